// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define FRM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define FRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/frm_pkg.sv =====
// Types and constants for the frame RMS meter.
package frm_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MAX_FRAME = 4096;
  localparam int unsigned CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int unsigned SQ_W      = 2 * SAMPLE_W - 1;
  localparam int unsigned SUM_W     = SQ_W + CNT_W - 1;
  localparam int unsigned MEAN_W    = 2 * SAMPLE_W;
  localparam int unsigned RMS_W     = 16;
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } frame_t;

endpackage

// ===== src/frame_rms_meter.sv =====
// Frame RMS meter top level: front end, frame queue and divide/square-root back end.
//
// Input channel: in_valid_i, sample_i (signed Q1.15), last_i; the block drives
// in_stall_o. A transfer happens at a clock edge with valid high and stall low.
// Output channel: out_valid_o, rms_o (unsigned Q1.15), frame_too_long_o; the
// receiver drives out_stall_i. One result per frame, on its last sample.
// Samples are taken one per cycle while in_stall_o is low. The square goes
// through one register stage before the 43-bit accumulator; a frame's last
// sample is pushed from that stage into a two-entry queue once the queue has
// room. The back end then loads the frame, runs a bit-serial division and a
// bit-serial square root, and holds the result in its result register. It
// takes a new frame only after it has finished the last one, so frames that
// arrive faster than it finishes them fill the queue and raise in_stall_o.
// At most 4096 samples per frame are accumulated; later ones set the
// frame_too_long_o flag. While out_stall_i holds a result, the back end
// waits and the queue absorbs up to two more frames before the input stalls.
// Reset clears the accumulator, count, queue and back end state.
`include "assert_macros.svh"

module frame_rms_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [frm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [frm_pkg::RMS_W-1:0]           rms_o,
  output logic                                frame_too_long_o
);
  import frm_pkg::*;

  logic   q_push, q_pop, q_full, q_empty;
  frame_t q_wdata, q_rdata;

  frm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .frame_o    (q_wdata)
  );

  frm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  frm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .frame_i          (q_rdata),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rms_o            (rms_o),
    .frame_too_long_o (frame_too_long_o)
  );

  `FRM_ASSERT(a_queue_no_overflow, !(q_push && q_full), "frame queue written while full")
  `FRM_ASSERT(a_stall_only_full, !in_stall_o || q_full, "input stalled with room in queue")
  `FRM_ASSERT(a_rms_range, !out_valid_o || rms_o <= 16'h8000, "rms above full scale")
  `FRM_ASSERT_NEXT(a_pop_hides_out, q_pop, !out_valid_o, "result shown while frame in work")

endmodule

// ===== src/frm_front.sv =====
// Front end: squares samples, counts them and hands finished frames to the queue.
module frm_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [frm_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic                                   last_i,
  input  logic                                   full_i,
  output logic                                   push_o,
  output frm_pkg::frame_t                        frame_o
);
  import frm_pkg::*;

  logic                 accept;
  logic                 advance;
  logic                 keep;
  logic [SAMPLE_W-1:0]  mag;
  logic [2*SAMPLE_W-1:0] prod;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_last_q;
  logic             s1_keep_q;
  logic [SQ_W-1:0]  s1_sq_q;
  logic [CNT_W-1:0] s1_cnt_q;
  logic             s1_ovf_q;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0] sum_new;

  assign advance    = !(s1_valid_q && s1_last_q && full_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;
  assign keep       = cnt_q < CNT_W'(MAX_FRAME);

  assign mag  = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
  assign prod = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (keep) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      if (last_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end
    end
  end

  assign s1_valid_d = advance ? accept : s1_valid_q;

  assign sum_new = sum_q + (s1_keep_q ? SUM_W'(s1_sq_q) : '0);

  always_comb begin
    sum_d = sum_q;
    if (advance && s1_valid_q) begin
      sum_d = s1_last_q ? '0 : sum_new;
    end
  end

  assign push_o      = s1_valid_q && s1_last_q && !full_i;
  assign frame_o.sum = sum_new;
  assign frame_o.cnt = s1_cnt_q;
  assign frame_o.ovf = s1_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      s1_valid_q <= s1_valid_d;
      sum_q      <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= last_i;
      s1_keep_q <= keep;
      s1_sq_q   <= prod[SQ_W-1:0];
      s1_cnt_q  <= keep ? cnt_q + 1'b1 : cnt_q;
      s1_ovf_q  <= ovf_q || !keep;
    end
  end

endmodule

// ===== src/frm_queue.sv =====
// Two-entry queue of finished frame totals between front and back end.
module frm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  frm_pkg::frame_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output frm_pkg::frame_t data_o
);
  import frm_pkg::*;

  frame_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/frm_back.sv =====
// Back end: serial divide of the sum by the count, serial square root, result register.
module frm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  frm_pkg::frame_t             frame_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [frm_pkg::RMS_W-1:0]   rms_o,
  output logic                        frame_too_long_o
);
  import frm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;

  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic              ovf_q;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;

  logic [MEAN_W-1:0] v_q, v_d;
  logic [MEAN_W-1:0] root_q, root_d;
  logic [MEAN_W-1:0] bit_q, bit_d;
  logic [MEAN_W:0]   trial;
  logic              fits;

  logic [RMS_W-1:0]  rms_q, rms_d;

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge      = rem_sh >= {1'b0, div_q};

  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign fits  = {1'b0, v_q} >= trial;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    v_d     = v_q;
    root_d  = root_q;
    bit_d   = bit_q;
    rms_d   = rms_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          rem_d   = '0;
          quo_d   = frame_i.sum;
          step_d  = DIV_CNT_W'(SUM_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_d  = {quo_q[SUM_W-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          v_d     = (div_q == '0) ? '0 : quo_d[MEAN_W-1:0];
          root_d  = '0;
          bit_d   = MEAN_W'(1) << (MEAN_W - 2);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (fits) begin
          v_d    = v_q - trial[MEAN_W-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          rms_d   = root_d[RMS_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o      = state_q == ST_OUT;
  assign rms_o            = rms_q;
  assign frame_too_long_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    v_q    <= v_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    rms_q  <= rms_d;
    if (pop_o) begin
      div_q <= frame_i.cnt;
      ovf_q <= frame_i.ovf;
    end
  end

endmodule
